// ----- src/ow_seq_pkg.sv -----
// Shared types and constants for the one-wire temperature read sequencer.
// No dependencies; every other file refers to this package by scoped names.
package ow_seq_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int CntW     = 20;

  localparam logic [CfgIdxW-1:0] RegResetLow     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresenceWait = 3'd1;
  localparam logic [CfgIdxW-1:0] RegResetRecover = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlot         = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWriteLow     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReadLow      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegReadSample   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegConvertWait  = 3'd7;

  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadPad = 8'hBE;

  typedef struct packed {
    logic [11:0] reset_low_ticks;
    logic [11:0] presence_wait_ticks;
    logic [11:0] reset_recover_ticks;
    logic [11:0] slot_ticks;
    logic [7:0]  write_low_ticks;
    logic [7:0]  read_low_ticks;
    logic [7:0]  read_sample_ticks;
    logic [19:0] convert_wait_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic command;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] raw_low;
    logic [7:0] raw_high;
    logic [2:0] tens_digit;
    logic [3:0] ones_digit;
    logic [3:0] tenths_digit;
    logic [3:0] hundredths_digit;
    logic [3:0] thousandths_digit;
    logic [3:0] ten_thousandths_digit;
    logic       forties_flag;
  } out_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
  } seq_status_t;

  // Four BCD digits of nibble * 625.
  function automatic logic [15:0] frac_bcd(input logic [3:0] nib);
    logic [15:0] r;
    case (nib)
      4'd0:    r = 16'h0000;
      4'd1:    r = 16'h0625;
      4'd2:    r = 16'h1250;
      4'd3:    r = 16'h1875;
      4'd4:    r = 16'h2500;
      4'd5:    r = 16'h3125;
      4'd6:    r = 16'h3750;
      4'd7:    r = 16'h4375;
      4'd8:    r = 16'h5000;
      4'd9:    r = 16'h5625;
      4'd10:   r = 16'h6250;
      4'd11:   r = 16'h6875;
      4'd12:   r = 16'h7500;
      4'd13:   r = 16'h8125;
      4'd14:   r = 16'h8750;
      default: r = 16'h9375;
    endcase
    return r;
  endfunction

endpackage

// ----- src/one_wire_temp_read_sequencer.sv -----
// One-wire temperature read sequencer. Each input item is one bus tick and yields exactly
// one result item: line drive, busy and done flags, the last bytes read and their decimal
// digits. Items are taken one per clock while the result buffer is not full; an accepted
// item passes the input register, then the one-tick sequencer step into a two-entry result
// buffer. The user must make configuration writes only while no item is in flight; the block does not enforce this.
module one_wire_temp_read_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ow_seq_pkg::in_item_t            in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ow_seq_pkg::out_item_t           out_item,
  input  logic                            cfg_we,
  input  logic [ow_seq_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ow_seq_pkg::CfgDataW-1:0] cfg_data
);

  ow_seq_pkg::cfg_regs_t   regs;
  ow_seq_pkg::in_item_t    s1_item;
  ow_seq_pkg::seq_status_t status;
  ow_seq_pkg::out_item_t   result;
  logic                    s1_valid;
  logic                    buf_full;
  logic                    advance;

  assign advance  = s1_valid && !buf_full;
  assign in_stall = s1_valid && buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && !in_stall) || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  ow_seq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  ow_seq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .regs   (regs),
    .status (status)
  );

  ow_seq_digits u_digits (
    .status (status),
    .result (result)
  );

  ow_seq_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_item (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- src/ow_seq_cfg.sv -----
// Timing register file of the one-wire sequencer.
// Depends on ow_seq_pkg.
module ow_seq_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ow_seq_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ow_seq_pkg::CfgDataW-1:0]     cfg_data,
  output ow_seq_pkg::cfg_regs_t               regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reset_low_ticks     <= 12'd503;
      regs.presence_wait_ticks <= 12'd70;
      regs.reset_recover_ticks <= 12'd430;
      regs.slot_ticks          <= 12'd63;
      regs.write_low_ticks     <= 8'd2;
      regs.read_low_ticks      <= 8'd6;
      regs.read_sample_ticks   <= 8'd4;
      regs.convert_wait_ticks  <= 20'd750000;
    end else if (cfg_we) begin
      case (cfg_index)
        ow_seq_pkg::RegResetLow:     regs.reset_low_ticks     <= cfg_data[11:0];
        ow_seq_pkg::RegPresenceWait: regs.presence_wait_ticks <= cfg_data[11:0];
        ow_seq_pkg::RegResetRecover: regs.reset_recover_ticks <= cfg_data[11:0];
        ow_seq_pkg::RegSlot:         regs.slot_ticks          <= cfg_data[11:0];
        ow_seq_pkg::RegWriteLow:     regs.write_low_ticks     <= cfg_data[7:0];
        ow_seq_pkg::RegReadLow:      regs.read_low_ticks      <= cfg_data[7:0];
        ow_seq_pkg::RegReadSample:   regs.read_sample_ticks   <= cfg_data[7:0];
        ow_seq_pkg::RegConvertWait:  regs.convert_wait_ticks  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/ow_seq_ctrl.sv -----
// Bus sequencer: phase machine, tick counter, bit shifter and byte stores.
// Advances one tick per step. Depends on ow_seq_pkg.
module ow_seq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  ow_seq_pkg::in_item_t      item,
  input  ow_seq_pkg::cfg_regs_t     regs,
  output ow_seq_pkg::seq_status_t   status
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhRstLow   = 4'd1;
  localparam logic [3:0] PhRstWait  = 4'd2;
  localparam logic [3:0] PhRecRetry = 4'd3;
  localparam logic [3:0] PhRecOk    = 4'd4;
  localparam logic [3:0] PhWrLow    = 4'd5;
  localparam logic [3:0] PhWrHold   = 4'd6;
  localparam logic [3:0] PhConvert  = 4'd7;
  localparam logic [3:0] PhRdLow    = 4'd8;
  localparam logic [3:0] PhRdWait   = 4'd9;
  localparam logic [3:0] PhRdRest   = 4'd10;

  logic [3:0]                  phase, phase_next;
  logic [ow_seq_pkg::CntW-1:0] tick_count, tick_count_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [2:0]                  byte_step, byte_step_next;
  logic [7:0]                  shift_reg, shift_reg_next;
  logic [7:0]                  low_byte_store, low_byte_store_next;
  logic [7:0]                  high_byte_store, high_byte_store_next;
  logic [ow_seq_pkg::CntW:0]   len, cnt_inc;
  logic                        drive, done;

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    bit_index_next       = bit_index;
    byte_step_next       = byte_step;
    shift_reg_next       = shift_reg;
    low_byte_store_next  = low_byte_store;
    high_byte_store_next = high_byte_store;
    drive                = 1'b0;
    done                 = 1'b0;

    if (phase_next > PhRdRest) begin
      phase_next = PhIdle;
    end
    if (phase_next == PhIdle && item.command) begin
      phase_next      = PhRstLow;
      tick_count_next = '0;
      byte_step_next  = 3'd0;
      bit_index_next  = 3'd0;
    end

    if (phase_next == PhRstLow || phase_next == PhWrLow || phase_next == PhRdLow) begin
      drive = 1'b1;
    end else if (phase_next == PhWrHold) begin
      drive = ~shift_reg_next[0];
    end

    case (phase_next)
      PhRstLow:              len = {9'd0, regs.reset_low_ticks};
      PhRstWait:             len = {9'd0, regs.presence_wait_ticks};
      PhRecRetry, PhRecOk:   len = {9'd0, regs.reset_recover_ticks};
      PhWrLow:               len = {13'd0, regs.write_low_ticks};
      PhConvert:             len = {1'b0, regs.convert_wait_ticks};
      PhRdLow:               len = {13'd0, regs.read_low_ticks};
      PhRdWait:              len = {13'd0, regs.read_sample_ticks};
      default:               len = {9'd0, regs.slot_ticks};
    endcase
    cnt_inc = {1'b0, tick_count_next} + 21'd1;

    if (phase_next != PhIdle) begin
      if (cnt_inc >= len) begin
        tick_count_next = '0;
        case (phase_next)
          PhRstLow:   phase_next = PhRstWait;
          PhRstWait:  phase_next = item.line_level ? PhRecRetry : PhRecOk;
          PhRecRetry: phase_next = PhRstLow;
          PhRecOk: begin
            shift_reg_next = ow_seq_pkg::CmdSkipRom;
            bit_index_next = 3'd0;
            phase_next     = PhWrLow;
          end
          PhWrLow:    phase_next = PhWrHold;
          PhWrHold: begin
            shift_reg_next = {1'b0, shift_reg_next[7:1]};
            if (bit_index_next == 3'd7) begin
              bit_index_next = 3'd0;
              case (byte_step_next)
                3'd0: begin
                  byte_step_next = 3'd1;
                  shift_reg_next = ow_seq_pkg::CmdConvert;
                  phase_next     = PhWrLow;
                end
                3'd1: begin
                  byte_step_next = 3'd2;
                  phase_next     = PhConvert;
                end
                3'd2: begin
                  byte_step_next = 3'd3;
                  shift_reg_next = ow_seq_pkg::CmdReadPad;
                  phase_next     = PhWrLow;
                end
                default: begin
                  byte_step_next = 3'd4;
                  shift_reg_next = 8'd0;
                  phase_next     = PhRdLow;
                end
              endcase
            end else begin
              bit_index_next = bit_index_next + 3'd1;
              phase_next     = PhWrLow;
            end
          end
          PhConvert:  phase_next = PhRstLow;
          PhRdLow:    phase_next = PhRdWait;
          PhRdWait: begin
            shift_reg_next = {item.line_level, shift_reg_next[7:1]};
            phase_next     = PhRdRest;
          end
          default: begin
            if (bit_index_next != 3'd7) begin
              bit_index_next = bit_index_next + 3'd1;
              phase_next     = PhRdLow;
            end else begin
              bit_index_next = 3'd0;
              if (byte_step_next == 3'd4) begin
                low_byte_store_next = shift_reg_next;
                byte_step_next      = 3'd5;
                shift_reg_next      = 8'd0;
                phase_next          = PhRdLow;
              end else begin
                high_byte_store_next = shift_reg_next;
                phase_next           = PhIdle;
                done                 = 1'b1;
              end
            end
          end
        endcase
      end else begin
        tick_count_next = cnt_inc[ow_seq_pkg::CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PhIdle;
      tick_count      <= '0;
      bit_index       <= 3'd0;
      byte_step       <= 3'd0;
      shift_reg       <= 8'd0;
      low_byte_store  <= 8'd0;
      high_byte_store <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      bit_index       <= bit_index_next;
      byte_step       <= byte_step_next;
      shift_reg       <= shift_reg_next;
      low_byte_store  <= low_byte_store_next;
      high_byte_store <= high_byte_store_next;
    end
  end

  assign status.drive_low = drive;
  assign status.busy      = (phase_next != PhIdle);
  assign status.done      = done;
  assign status.low_byte  = low_byte_store_next;
  assign status.high_byte = high_byte_store_next;

endmodule

// ----- src/ow_seq_digits.sv -----
// Builds the result item: raw bytes and decimal digits of the temperature.
// Depends on ow_seq_pkg.
module ow_seq_digits (
  input  ow_seq_pkg::seq_status_t status,
  output ow_seq_pkg::out_item_t   result
);

  logic [5:0]  tz;
  logic [13:0] tz_scaled;
  logic [2:0]  tens;
  logic [5:0]  tens_x10;
  logic [5:0]  ones;
  logic [15:0] frac;

  assign tz        = {status.high_byte[1:0], status.low_byte[7:4]};
  // tz * 205 >> 11 is tz / 10 for tz below 64
  assign tz_scaled = {8'd0, tz} * 14'd205;
  assign tens      = tz_scaled[13:11];
  assign tens_x10  = {tens, 3'd0} + {2'd0, tens, 1'b0};
  assign ones      = tz - tens_x10;
  assign frac      = ow_seq_pkg::frac_bcd(status.low_byte[3:0]);

  assign result.drive_low             = status.drive_low;
  assign result.busy_res              = status.busy;
  assign result.done_res              = status.done;
  assign result.raw_low               = status.low_byte;
  assign result.raw_high              = status.high_byte;
  assign result.tens_digit            = tens;
  assign result.ones_digit            = ones[3:0];
  assign result.tenths_digit          = frac[15:12];
  assign result.hundredths_digit      = frac[11:8];
  assign result.thousandths_digit     = frac[7:4];
  assign result.ten_thousandths_digit = frac[3:0];
  assign result.forties_flag          = (tens == 3'd4);

endmodule

// ----- src/ow_seq_obuf.sv -----
// Two-entry result buffer between the sequencer and the output channel.
// Depends on ow_seq_pkg.
module ow_seq_obuf (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ow_seq_pkg::out_item_t   push_item,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ow_seq_pkg::out_item_t   out_item
);

  logic [1:0]            count, count_next;
  ow_seq_pkg::out_item_t head, skid;
  logic                  pop;

  assign pop       = (count != 2'd0) && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = head;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (count == 2'd2) begin
      if (pop) begin
        head <= skid;
      end
    end else if (push) begin
      if (count == 2'd0 || pop) begin
        head <= push_item;
      end else begin
        skid <= push_item;
      end
    end
  end

endmodule

// ----- src/ow_seq_checker.sv -----
// Port-level checks of the one-wire sequencer, bound to the top level.
// Depends on ow_seq_pkg.
module ow_seq_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input ow_seq_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done while still busy");

  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.busy_res && !out_item.done_res |-> !out_item.drive_low)
    else $error("line driven while idle");

  a_forties: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.forties_flag == (out_item.tens_digit == 3'd4))
    else $error("forties flag mismatch");

endmodule

bind one_wire_temp_read_sequencer ow_seq_checker u_ow_seq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
